@@ design/palmdoc_lz77_decompressor_macros.svh @@
// Assertion macros for the PalmDoc LZ77 decompressor.
`ifndef PALMDOC_LZ77_DECOMPRESSOR_MACROS_SVH
`define PALMDOC_LZ77_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLZ77_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLZ77_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/plz77_pkg.sv @@
// Shared constants and types of the PalmDoc LZ77 decompressor.
package plz77_pkg;

  localparam int HISTORY_DEPTH = 2048;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int DIST_W        = 11;
  localparam int CNT_W         = 11;
  localparam int LEN_W         = 4;
  localparam int LIT_W         = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 11'h7FF;
  localparam logic [7:0]       SPACE_BYTE = 8'h20;
  localparam logic [7:0]       HIGH_FLIP  = 8'h80;
  localparam logic [7:0]       PLAIN_MAX  = 8'h7F;
  localparam logic [7:0]       LIT_MAX    = 8'h08;
  localparam logic [LEN_W-1:0] LEN_BIAS   = 4'd3;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ONE,
    KIND_SPACE,
    KIND_COPY,
    KIND_BAD
  } kind_t;

  typedef enum logic [2:0] {
    SRC_IN,
    SRC_SPACE,
    SRC_SECOND,
    SRC_COPY,
    SRC_ERR
  } src_t;

  typedef struct packed {
    logic  take_item;
    logic  load_out;
    src_t  src;
    logic  last;
    logic  hist_read;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  out_free;
    logic  copy_last;
  } sts_t;

endpackage

@@ design/plz77_ctrl.sv @@
// Controller state machine of the PalmDoc LZ77 decompressor.
module plz77_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  plz77_pkg::sts_t    sts,
  output plz77_pkg::cmd_t    cmd,
  output logic               in_stall
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SECOND  = 4'b0010,
    ST_COPY_RD = 4'b0100,
    ST_COPY_WR = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = !((state == ST_IDLE) && sts.out_free);

  always_comb begin
    state_next    = state;
    cmd.take_item = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.src       = plz77_pkg::SRC_IN;
    cmd.last      = 1'b1;
    cmd.hist_read = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid && sts.out_free) begin
          cmd.take_item = 1'b1;
          case (sts.kind)
            plz77_pkg::KIND_ONE: begin
              cmd.load_out = 1'b1;
              cmd.src      = plz77_pkg::SRC_IN;
            end
            plz77_pkg::KIND_SPACE: begin
              cmd.load_out = 1'b1;
              cmd.src      = plz77_pkg::SRC_SPACE;
              cmd.last     = 1'b0;
              state_next   = ST_SECOND;
            end
            plz77_pkg::KIND_BAD: begin
              cmd.load_out = 1'b1;
              cmd.src      = plz77_pkg::SRC_ERR;
            end
            plz77_pkg::KIND_COPY: begin
              state_next = ST_COPY_RD;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_SECOND: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.src      = plz77_pkg::SRC_SECOND;
          state_next   = ST_IDLE;
        end
      end
      ST_COPY_RD: begin
        cmd.hist_read = 1'b1;
        state_next    = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.src      = plz77_pkg::SRC_COPY;
          cmd.last     = sts.copy_last;
          state_next   = sts.copy_last ? ST_IDLE : ST_COPY_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/plz77_datapath.sv @@
// Datapath of the PalmDoc LZ77 decompressor: decode, history memory, output register.
module plz77_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       data_byte,
  input  logic             record_start,
  input  plz77_pkg::cmd_t  cmd,
  output plz77_pkg::sts_t  sts,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             distance_error
);

  logic [7:0] hist_mem [plz77_pkg::HISTORY_DEPTH];
  logic [7:0] rd_data;

  logic [plz77_pkg::HIST_AW-1:0]  wp;
  logic [plz77_pkg::CNT_W-1:0]    cnt;
  logic [plz77_pkg::LIT_W-1:0]    lit;
  logic                           pair;
  logic [5:0]                     pair_high;
  logic [plz77_pkg::DIST_W-1:0]   copy_dist;
  logic [plz77_pkg::LEN_W-1:0]    remain;
  logic [7:0]                     second;

  logic                           clr;
  logic [plz77_pkg::HIST_AW-1:0]  wp_eff;
  logic [plz77_pkg::CNT_W-1:0]    cnt_eff;
  logic [plz77_pkg::LIT_W-1:0]    lit_eff;
  logic                           pair_eff;
  logic [plz77_pkg::DIST_W-1:0]   dist_in;
  logic [plz77_pkg::LEN_W-1:0]    len_in;
  logic                           is_lit_code;
  logic                           is_pair_code;
  plz77_pkg::kind_t               kind;
  logic [plz77_pkg::LIT_W-1:0]    lit_next;
  logic [plz77_pkg::HIST_AW-1:0]  dist_ext;
  logic [plz77_pkg::HIST_AW:0]    rd_wrap;
  logic [plz77_pkg::HIST_AW-1:0]  rd_addr;
  logic [7:0]                     wdata;
  logic                           hist_we;

  assign clr      = cmd.take_item && record_start;
  assign wp_eff   = clr ? '0 : wp;
  assign cnt_eff  = clr ? '0 : cnt;
  assign lit_eff  = record_start ? '0 : lit;
  assign pair_eff = record_start ? 1'b0 : pair;

  assign dist_in      = {pair_high, data_byte[7:3]};
  assign len_in       = {1'b0, data_byte[2:0]} + plz77_pkg::LEN_BIAS;
  assign is_lit_code  = (data_byte != 8'h00) && (data_byte <= plz77_pkg::LIT_MAX);
  assign is_pair_code = (data_byte[7:6] == 2'b10);

  always_comb begin
    lit_next = '0;
    if (lit_eff != '0) begin
      kind     = plz77_pkg::KIND_ONE;
      lit_next = lit_eff - 1'b1;
    end else if (pair_eff) begin
      if ((dist_in == '0) || (dist_in > cnt_eff)) begin
        kind = plz77_pkg::KIND_BAD;
      end else begin
        kind = plz77_pkg::KIND_COPY;
      end
    end else if (is_lit_code) begin
      kind     = plz77_pkg::KIND_NONE;
      lit_next = data_byte[plz77_pkg::LIT_W-1:0];
    end else if (data_byte <= plz77_pkg::PLAIN_MAX) begin
      kind = plz77_pkg::KIND_ONE;
    end else if (!is_pair_code) begin
      kind = plz77_pkg::KIND_SPACE;
    end else begin
      kind = plz77_pkg::KIND_NONE;
    end
  end

  assign sts.kind      = kind;
  assign sts.out_free  = !out_valid || !out_stall;
  assign sts.copy_last = (remain == plz77_pkg::LEN_W'(1));

  assign dist_ext = plz77_pkg::HIST_AW'(copy_dist);
  assign rd_wrap  = {1'b0, wp} + (plz77_pkg::HIST_AW + 1)'(plz77_pkg::HISTORY_DEPTH)
                    - {1'b0, dist_ext};
  assign rd_addr  = (wp >= dist_ext) ? (wp - dist_ext) : rd_wrap[plz77_pkg::HIST_AW-1:0];

  always_comb begin
    case (cmd.src)
      plz77_pkg::SRC_IN:     wdata = data_byte;
      plz77_pkg::SRC_SPACE:  wdata = plz77_pkg::SPACE_BYTE;
      plz77_pkg::SRC_SECOND: wdata = second;
      plz77_pkg::SRC_COPY:   wdata = rd_data;
      default:               wdata = 8'h00;
    endcase
  end

  assign hist_we = cmd.load_out && (cmd.src != plz77_pkg::SRC_ERR);

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp_eff] <= wdata;
    end
    if (cmd.hist_read) begin
      rd_data <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      cnt       <= '0;
      lit       <= '0;
      pair      <= 1'b0;
      pair_high <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (hist_we) begin
        wp  <= (wp_eff == plz77_pkg::HIST_AW'(plz77_pkg::HISTORY_DEPTH - 1)) ? '0
                                                                              : wp_eff + 1'b1;
        cnt <= (cnt_eff == plz77_pkg::COUNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
      end else if (clr) begin
        wp  <= '0;
        cnt <= '0;
      end
      if (cmd.take_item) begin
        lit       <= lit_next;
        pair      <= (lit_eff == '0) && !pair_eff && is_pair_code;
        pair_high <= ((lit_eff == '0) && !pair_eff) ? data_byte[5:0] : '0;
        if (kind == plz77_pkg::KIND_COPY) begin
          remain <= len_in;
        end
      end else if (cmd.load_out && (cmd.src == plz77_pkg::SRC_COPY)) begin
        remain <= remain - 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      copy_dist <= dist_in;
      second    <= data_byte ^ plz77_pkg::HIGH_FLIP;
    end
    if (cmd.load_out) begin
      out_byte       <= wdata;
      last_of_run    <= cmd.last;
      distance_error <= (cmd.src == plz77_pkg::SRC_ERR);
    end
  end

endmodule

@@ design/palmdoc_lz77_decompressor.sv @@
// PalmDoc LZ77 decompressor top level.
// Takes one compressed byte per input word and returns the decompressed bytes
// it completes, one output word per byte, with last_of_run on the final one.
// A word that produces one byte, or none (literal count or first byte of a
// back-reference), is handled in ST_IDLE; a space-pair code adds ST_SECOND.
// The second byte of a back-reference passes ST_COPY_RD then ST_COPY_WR for
// each of its 3 to 10 copied bytes, since each is read from the history memory
// and written back before the next read. A bad distance gives one word with
// distance_error set and byte 0. An output register holds the last byte; while
// that byte waits on out_stall, in_stall stays high and no input word is taken.
`include "palmdoc_lz77_decompressor_macros.svh"

module palmdoc_lz77_decompressor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       record_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       distance_error
);

  plz77_pkg::cmd_t cmd;
  plz77_pkg::sts_t sts;
  logic            in_take;
  logic            copy_take;

  plz77_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  plz77_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .record_start   (record_start),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .last_of_run    (last_of_run),
    .distance_error (distance_error)
  );

  assign in_take   = in_valid && !in_stall;
  assign copy_take = in_take && (sts.kind == plz77_pkg::KIND_COPY);

  `PLZ77_ASSERT_NOW(a_load_needs_room, cmd.load_out, sts.out_free, "output word overwritten")
  `PLZ77_ASSERT_NOW(a_no_read_on_take, in_take, !cmd.hist_read, "read during take")
  `PLZ77_ASSERT_NOW(a_err_word, out_valid && distance_error, last_of_run && !(|out_byte), "error word")
  `PLZ77_ASSERT_NEXT(a_copy_reads_first, copy_take, cmd.hist_read && !cmd.load_out, "no copy read")

endmodule

@@ verif/tb_palmdoc_lz77_decompressor.sv @@
// Self-checking testbench for the PalmDoc LZ77 decompressor, with its byte predictor.
typedef struct packed {
  logic [7:0] value;
  logic       last;
  logic       err;
} out_word_t;

typedef struct packed {
  logic [7:0] code;
  logic       start;
} code_word_t;

class lz77_predictor;
  localparam logic [7:0] SPACE_CODE_MIN = 8'hC0;

  logic [7:0]                    hist [plz77_pkg::HISTORY_DEPTH];
  logic [plz77_pkg::HIST_AW-1:0] wr_ptr;
  logic [plz77_pkg::CNT_W-1:0]   made;
  logic [plz77_pkg::LIT_W-1:0]   lits_left;
  logic                          pair_open;
  logic [5:0]                    pair_hi;
  out_word_t                     pending_bytes [$];
  int                            words_in;
  int                            bytes_out;
  int                            bad_dists;
  int                            mismatches;

  function new();
    wr_ptr     = '0;
    made       = '0;
    lits_left  = '0;
    pair_open  = 1'b0;
    pair_hi    = '0;
    words_in   = 0;
    bytes_out  = 0;
    bad_dists  = 0;
    mismatches = 0;
  endfunction

  function void put_byte(logic [7:0] v);
    hist[wr_ptr] = v;
    wr_ptr++;
    if (made != plz77_pkg::COUNT_MAX) made++;
    pending_bytes.push_back(out_word_t'{value: v, last: 1'b0, err: 1'b0});
  endfunction

  function void take_code_byte(logic [7:0] b, logic s);
    int                            first;
    int                            n;
    logic [13:0]                   pair_code;
    logic [plz77_pkg::DIST_W-1:0]  copy_dist;
    logic [plz77_pkg::LEN_W-1:0]   len;
    logic [plz77_pkg::HIST_AW-1:0] rd_ptr;
    first = pending_bytes.size();
    words_in++;
    if (s) begin
      lits_left = '0;
      pair_open = 1'b0;
      pair_hi   = '0;
      made      = '0;
      wr_ptr    = '0;
    end
    if (lits_left != 0) begin
      lits_left--;
      put_byte(b);
    end else if (pair_open) begin
      pair_code = {pair_hi, b};
      copy_dist = pair_code[13:3];
      len       = pair_code[2:0] + plz77_pkg::LEN_BIAS;
      pair_open = 1'b0;
      pair_hi   = '0;
      if (copy_dist == 0 || copy_dist > made) begin
        bad_dists++;
        pending_bytes.push_back(out_word_t'{value: 8'h00, last: 1'b0, err: 1'b1});
      end else begin
        for (n = 0; n < len; n++) begin
          rd_ptr = wr_ptr - copy_dist;
          put_byte(hist[rd_ptr]);
        end
      end
    end else if (b >= 8'd1 && b <= plz77_pkg::LIT_MAX) begin
      lits_left = b[plz77_pkg::LIT_W-1:0];
    end else if (b <= plz77_pkg::PLAIN_MAX) begin
      put_byte(b);
    end else if (b >= SPACE_CODE_MIN) begin
      put_byte(plz77_pkg::SPACE_BYTE);
      put_byte(b ^ plz77_pkg::HIGH_FLIP);
    end else begin
      pair_open = 1'b1;
      pair_hi   = b[5:0];
    end
    if (pending_bytes.size() > first) pending_bytes[pending_bytes.size()-1].last = 1'b1;
  endfunction

  function void flag(string what, out_word_t want, out_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d, %s: expected byte %02h last %0b err %0b, got byte %02h last %0b err %0b",
               mismatches, what, want.value, want.last, want.err, got.value, got.last, got.err);
  endfunction

  function void check_out_word(logic [7:0] v, logic l, logic e);
    out_word_t want;
    out_word_t got;
    got = out_word_t'{value: v, last: l, err: e};
    bytes_out++;
    if (pending_bytes.size() == 0) begin
      flag("word with nothing pending", '0, got);
    end else begin
      want = pending_bytes.pop_front();
      if (got.value !== want.value || got.last !== want.last || got.err !== want.err)
        flag("word differs", want, got);
    end
  endfunction
endclass

module tb_palmdoc_lz77_decompressor;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_WORDS  = 85;

  logic       clk;
  logic       rst          = 1'b1;
  logic       in_valid     = 1'b0;
  logic [7:0] data_byte    = '0;
  logic       record_start = 1'b0;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       distance_error;

  lz77_predictor sb = new();
  code_word_t    word_q [$];
  logic          pending_start = 1'b0;
  int            gen_made      = 0;
  int            snd_idle_pct  = 0;
  int            rcv_idle_pct  = 0;
  logic          hold_req      = 1'b0;
  int            cycle_count   = 0;
  int            stall_cycles  = 0;

  palmdoc_lz77_decompressor DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Check output words before noting the input word taken at the same edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_out_word(out_byte, last_of_run, distance_error);
      if (in_valid && !in_stall) sb.take_code_byte(data_byte, record_start);
      if (in_valid && in_stall) stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
        @(posedge clk);
      end
    end
  end

  function automatic void push_word(logic [7:0] b);
    word_q.push_back(code_word_t'{code: b, start: pending_start});
    pending_start = 1'b0;
  endfunction

  function automatic void add_made(int n);
    gen_made = (gen_made + n > plz77_pkg::COUNT_MAX) ? plz77_pkg::COUNT_MAX : gen_made + n;
  endfunction

  function automatic void gen_copy(int long_pct);
    int          d;
    int          len_sel;
    bit          bad;
    logic [13:0] pair_code;
    bad = (gen_made == 0) || ($urandom_range(99) < 4);
    if (bad) begin
      d = (gen_made < plz77_pkg::COUNT_MAX && $urandom_range(1) == 1) ?
          $urandom_range(plz77_pkg::COUNT_MAX, gen_made + 1) : 0;
    end else begin
      case ($urandom_range(3))
        0: d = gen_made;
        1: d = $urandom_range(gen_made < 3 ? gen_made : 3, 1);
        default: d = $urandom_range(gen_made, 1);
      endcase
    end
    len_sel   = ($urandom_range(99) < long_pct) ? 7 : $urandom_range(7);
    pair_code = {d[10:0], len_sel[2:0]};
    push_word({2'b10, pair_code[13:8]});
    push_word(pair_code[7:0]);
    if (!bad) add_made(len_sel + 3);
  endfunction

  function automatic void gen_token(int copy_pct, int noise_pct, int long_pct);
    int r;
    int n;
    int k;
    if (noise_pct != 0 && $urandom_range(99) < 4) begin
      pending_start = 1'b1;
      gen_made      = 0;
    end
    r = $urandom_range(99);
    if (r < noise_pct) begin
      if ($urandom_range(1) == 1) begin
        push_word(8'($urandom_range(255)));
      end else begin
        // cut a code short and open a new record
        push_word(8'($urandom_range(1) == 1 ? $urandom_range(plz77_pkg::LIT_MAX, 1)
                                            : $urandom_range(191, 128)));
        pending_start = 1'b1;
        gen_made      = 0;
      end
    end else if (r < noise_pct + copy_pct) begin
      gen_copy(long_pct);
    end else begin
      case ($urandom_range(2))
        0: begin
          n = $urandom_range(plz77_pkg::LIT_MAX, 1);
          push_word(8'(n));
          for (k = 0; k < n; k++) push_word(8'($urandom_range(255)));
          add_made(n);
        end
        1: begin
          push_word(($urandom_range(7) == 0) ? 8'h00
                                             : 8'($urandom_range(plz77_pkg::PLAIN_MAX, 9)));
          add_made(1);
        end
        default: begin
          push_word(8'($urandom_range(255, 192)));
          add_made(2);
        end
      endcase
    end
  endfunction

  task automatic drive_words(input int hold_at);
    code_word_t w;
    int         k;
    k = 0;
    while (word_q.size() != 0) begin
      w = word_q.pop_front();
      if (k == hold_at) hold_req = 1'b1;
      if ($urandom_range(99) < snd_idle_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
      end
      in_valid     <= 1'b1;
      data_byte    <= w.code;
      record_start <= w.start;
      do @(posedge clk); while (in_stall);
      k++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    snd_idle_pct  = 31;
    rcv_idle_pct  = 81;
    pending_start = 1'b1;
    push_word(8'h00);
    push_word(8'h09);
    push_word(plz77_pkg::PLAIN_MAX);
    push_word(8'hC0);
    push_word(8'hFF);
    push_word(8'h01);
    push_word(8'hAB);
    push_word(plz77_pkg::LIT_MAX);
    push_word(8'h00);
    push_word(8'hFF);
    push_word(8'h80);
    push_word(8'h01);
    push_word(8'h08);
    push_word(8'hC0);
    push_word(plz77_pkg::PLAIN_MAX);
    push_word(8'h55);
    push_word(8'h80);   // distance 1, ten bytes, overlapping
    push_word(8'h0F);
    push_word(8'h80);   // distance zero
    push_word(8'h00);
    push_word(8'hBF);   // distance past the bytes made so far
    push_word(8'hFF);
    push_word(8'h03);   // literal run cut short by a new record
    pending_start = 1'b1;
    push_word(8'h85);   // pair cut short by a new record
    pending_start = 1'b1;
    push_word(8'h41);
    drive_words(-1);
    wait_drain();

    pending_start = 1'b1;
    gen_made      = 0;
    while (word_q.size() < PHASE_WORDS) gen_token(30, 12, 10);
    drive_words(-1);
    wait_drain();

    snd_idle_pct  = 81;
    rcv_idle_pct  = 31;
    pending_start = 1'b1;
    gen_made      = 0;
    while (word_q.size() < PHASE_WORDS) gen_token(30, 12, 10);
    drive_words(15);
    wait_drain();

    // back to back, mostly long copies
    snd_idle_pct  = 0;
    rcv_idle_pct  = 0;
    pending_start = 1'b1;
    gen_made      = 0;
    while (word_q.size() < PHASE_WORDS) gen_token(92, 0, 85);
    drive_words(-1);
    wait_drain();

    $display("covered %0d compressed words, %0d output words, %0d bad distances",
             sb.words_in, sb.bytes_out, sb.bad_dists);
    $display("input stalled for %0d cycles, including one %0d-cycle output hold",
             stall_cycles, HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/plz77_pkg.sv
design/plz77_ctrl.sv
design/plz77_datapath.sv
design/palmdoc_lz77_decompressor.sv
verif/tb_palmdoc_lz77_decompressor.sv
